// ===== rtl/usrw_pkg.sv =====
package usrw_pkg;

  localparam int GEN_W      = 31;
  localparam int DIR_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int POS_OUT_W  = 32;
  localparam int STEP_OUT_W = 18;
  localparam int LEN_W      = 31;
  localparam int SQ_W       = 62;
  localparam int CNT_W      = 5;

  localparam logic [17:0]      LCG_MUL    = 18'd214013;
  localparam logic [21:0]      LCG_ADD    = 22'd2531011;
  localparam logic [GEN_W-1:0] SEED_X_RST = 31'd1;
  localparam logic [GEN_W-1:0] SEED_Y_RST = 31'd202;
  localparam logic [DIR_W-1:0] HALF_RANGE = 32'h4000_0000;
  localparam logic [SQ_W-1:0]  ROOT_BIT0  = 62'h1000_0000_0000_0000;
  localparam logic [CNT_W-1:0] ROOT_LAST  = 5'd30;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_Y = 1'b1;

  typedef struct packed {
    logic signed [DIR_W-1:0] dx;
    logic signed [DIR_W-1:0] dy;
  } dir_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== rtl/usrw_if.sv =====
interface usrw_tick_if;
  logic valid;
  logic ready;
  logic tick;
  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

interface usrw_result_if;
  logic                                        valid;
  logic                                        ready;
  logic signed [usrw_pkg::POS_OUT_W-1:0]  pos_x;
  logic signed [usrw_pkg::POS_OUT_W-1:0]  pos_y;
  logic signed [usrw_pkg::STEP_OUT_W-1:0] step_x;
  logic signed [usrw_pkg::STEP_OUT_W-1:0] step_y;
  modport source (output valid, output pos_x, output pos_y, output step_x, output step_y,
                  input ready);
  modport sink (input valid, input pos_x, input pos_y, input step_x, input step_y,
                output ready);
endinterface

// ===== rtl/usrw_front.sv =====
module usrw_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [usrw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [usrw_pkg::GEN_W-1:0]         cfg_data,
  usrw_tick_if.sink                          in_ch,
  input  usrw_pkg::fifo_stat_t               stat,
  output logic                               push,
  output usrw_pkg::dir_t                     push_dir
);

  logic [usrw_pkg::GEN_W-1:0] gen_x;
  logic [usrw_pkg::GEN_W-1:0] gen_y;
  logic [48:0]                prod_x;
  logic [48:0]                prod_y;
  logic [usrw_pkg::GEN_W-1:0] gen_x_next;
  logic [usrw_pkg::GEN_W-1:0] gen_y_next;

  assign in_ch.ready = !stat.full;
  assign push        = in_ch.valid && in_ch.ready && in_ch.tick;

  assign prod_x = 49'(usrw_pkg::LCG_MUL) * 49'(gen_x) + 49'(usrw_pkg::LCG_ADD);
  assign prod_y = 49'(usrw_pkg::LCG_MUL) * 49'(gen_y) + 49'(usrw_pkg::LCG_ADD);
  assign gen_x_next = prod_x[usrw_pkg::GEN_W-1:0];
  assign gen_y_next = prod_y[usrw_pkg::GEN_W-1:0];

  assign push_dir.dx = $signed({1'b0, gen_x_next} - usrw_pkg::HALF_RANGE);
  assign push_dir.dy = $signed({1'b0, gen_y_next} - usrw_pkg::HALF_RANGE);

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_x <= usrw_pkg::SEED_X_RST;
      gen_y <= usrw_pkg::SEED_Y_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        usrw_pkg::CFG_SEED_X: gen_x <= cfg_data;
        usrw_pkg::CFG_SEED_Y: gen_y <= cfg_data;
        default: ;
      endcase
    end else if (push) begin
      gen_x <= gen_x_next;
      gen_y <= gen_y_next;
    end
  end

endmodule

// ===== rtl/usrw_fifo.sv =====
module usrw_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  usrw_pkg::dir_t       push_dir,
  input  logic                 pop,
  output usrw_pkg::dir_t       head,
  output usrw_pkg::fifo_stat_t stat
);

  usrw_pkg::dir_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign head       = mem[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_dir;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/usrw_back.sv =====
module usrw_back #(
  parameter int FRAC_BITS = 16,
  parameter int POS_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  usrw_pkg::fifo_stat_t stat,
  input  usrw_pkg::dir_t       head,
  output logic                 pop,
  usrw_result_if.source        out_ch
);

  localparam int NUM_W  = 32 + FRAC_BITS;
  localparam int STEP_W = FRAC_BITS + 2;
  localparam logic [usrw_pkg::CNT_W-1:0] DIV_LAST = usrw_pkg::CNT_W'(FRAC_BITS);

  typedef enum logic [2:0] {IDLE, SQUARE, ROOT, DIVIDE, ACCUM} state_t;

  state_t                          state;
  logic [usrw_pkg::LEN_W-1:0]      mag_x;
  logic [usrw_pkg::LEN_W-1:0]      mag_y;
  logic                            neg_x;
  logic                            neg_y;
  logic                            zero_dir;
  logic [usrw_pkg::SQ_W-1:0]       sq_x;
  logic [usrw_pkg::SQ_W-1:0]       sq_y;
  logic [usrw_pkg::SQ_W-1:0]       rn;
  logic [usrw_pkg::SQ_W-1:0]       root;
  logic [usrw_pkg::SQ_W-1:0]       rbit;
  logic [usrw_pkg::CNT_W-1:0]      cnt;
  logic [usrw_pkg::LEN_W-1:0]      len;
  logic [usrw_pkg::LEN_W-1:0]      rem_x;
  logic [usrw_pkg::LEN_W-1:0]      rem_y;
  logic [FRAC_BITS:0]              nb_x;
  logic [FRAC_BITS:0]              nb_y;
  logic signed [POS_WIDTH-1:0]     acc_x;
  logic signed [POS_WIDTH-1:0]     acc_y;
  logic signed [STEP_W-1:0]        step_x;
  logic signed [STEP_W-1:0]        step_y;
  logic                            out_valid;

  logic [usrw_pkg::SQ_W-1:0]       trial;
  logic [usrw_pkg::LEN_W-1:0]      len_next;
  logic [NUM_W-1:0]                num_x;
  logic [NUM_W-1:0]                num_y;
  logic [usrw_pkg::LEN_W:0]        t_x;
  logic [usrw_pkg::LEN_W:0]        t_y;
  logic                            ge_x;
  logic                            ge_y;
  logic signed [STEP_W-1:0]        sx_next;
  logic signed [STEP_W-1:0]        sy_next;
  logic signed [POS_WIDTH-1:0]     acc_x_next;
  logic signed [POS_WIDTH-1:0]     acc_y_next;
  logic                            out_free;

  function automatic logic signed [POS_WIDTH-1:0] sat_add(
    input logic signed [POS_WIDTH-1:0] a,
    input logic signed [STEP_W-1:0]    s
  );
    logic signed [POS_WIDTH:0] sum;
    sum = (POS_WIDTH+1)'(a) + (POS_WIDTH+1)'(s);
    if (sum[POS_WIDTH] != sum[POS_WIDTH-1]) begin
      sat_add = sum[POS_WIDTH] ? {1'b1, {(POS_WIDTH-1){1'b0}}}
                               : {1'b0, {(POS_WIDTH-1){1'b1}}};
    end else begin
      sat_add = sum[POS_WIDTH-1:0];
    end
  endfunction

  assign out_free = !out_valid || out_ch.ready;
  assign pop      = (state == IDLE) && !stat.empty;

  assign trial    = root + rbit;
  assign len_next = (rn >= trial) ? usrw_pkg::LEN_W'((root >> 1) + rbit)
                                  : usrw_pkg::LEN_W'(root >> 1);

  assign num_x = (NUM_W'(mag_x) << FRAC_BITS) + NUM_W'(len >> 1);
  assign num_y = (NUM_W'(mag_y) << FRAC_BITS) + NUM_W'(len >> 1);

  assign t_x  = {rem_x, nb_x[FRAC_BITS]};
  assign t_y  = {rem_y, nb_y[FRAC_BITS]};
  assign ge_x = t_x >= {1'b0, len};
  assign ge_y = t_y >= {1'b0, len};

  assign sx_next = neg_x ? -$signed({1'b0, nb_x}) : $signed({1'b0, nb_x});
  assign sy_next = neg_y ? -$signed({1'b0, nb_y}) : $signed({1'b0, nb_y});

  assign acc_x_next = sat_add(acc_x, zero_dir ? STEP_W'(0) : sx_next);
  assign acc_y_next = sat_add(acc_y, zero_dir ? STEP_W'(0) : sy_next);

  assign out_ch.valid  = out_valid;
  assign out_ch.pos_x  = usrw_pkg::POS_OUT_W'(acc_x);
  assign out_ch.pos_y  = usrw_pkg::POS_OUT_W'(acc_y);
  assign out_ch.step_x = usrw_pkg::STEP_OUT_W'(step_x);
  assign out_ch.step_y = usrw_pkg::STEP_OUT_W'(step_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      acc_x     <= '0;
      acc_y     <= '0;
    end else begin
      if (out_valid && out_ch.ready && state != ACCUM) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (pop) begin
            mag_x    <= usrw_pkg::LEN_W'(head.dx[usrw_pkg::DIR_W-1] ? -head.dx : head.dx);
            mag_y    <= usrw_pkg::LEN_W'(head.dy[usrw_pkg::DIR_W-1] ? -head.dy : head.dy);
            neg_x    <= head.dx[usrw_pkg::DIR_W-1];
            neg_y    <= head.dy[usrw_pkg::DIR_W-1];
            zero_dir <= (head.dx == '0) && (head.dy == '0);
            state    <= ((head.dx == '0) && (head.dy == '0)) ? ACCUM : SQUARE;
          end
        end
        SQUARE: begin
          sq_x  <= usrw_pkg::SQ_W'(mag_x) * usrw_pkg::SQ_W'(mag_x);
          sq_y  <= usrw_pkg::SQ_W'(mag_y) * usrw_pkg::SQ_W'(mag_y);
          rn    <= '0;
          root  <= '0;
          rbit  <= '0;
          cnt   <= '0;
          state <= ROOT;
        end
        ROOT: begin
          if (rbit == '0) begin
            rn   <= sq_x + sq_y;
            rbit <= usrw_pkg::ROOT_BIT0;
          end else if (cnt == usrw_pkg::ROOT_LAST) begin
            len   <= len_next;
            cnt   <= '0;
            rbit  <= usrw_pkg::ROOT_BIT0;
            state <= DIVIDE;
          end else begin
            if (rn >= trial) begin
              rn   <= rn - trial;
              root <= (root >> 1) + rbit;
            end else begin
              root <= root >> 1;
            end
            rbit <= rbit >> 2;
            cnt  <= cnt + 1'b1;
          end
        end
        DIVIDE: begin
          if (rbit != '0) begin
            rbit  <= '0;
            rem_x <= num_x[NUM_W-1:FRAC_BITS+1];
            rem_y <= num_y[NUM_W-1:FRAC_BITS+1];
            nb_x  <= num_x[FRAC_BITS:0];
            nb_y  <= num_y[FRAC_BITS:0];
          end else begin
            rem_x <= ge_x ? usrw_pkg::LEN_W'(t_x - {1'b0, len}) : usrw_pkg::LEN_W'(t_x);
            rem_y <= ge_y ? usrw_pkg::LEN_W'(t_y - {1'b0, len}) : usrw_pkg::LEN_W'(t_y);
            nb_x  <= {nb_x[FRAC_BITS-1:0], ge_x};
            nb_y  <= {nb_y[FRAC_BITS-1:0], ge_y};
            cnt   <= cnt + 1'b1;
            if (cnt == DIV_LAST) begin
              state <= ACCUM;
            end
          end
        end
        ACCUM: begin
          if (out_free) begin
            acc_x     <= acc_x_next;
            acc_y     <= acc_y_next;
            step_x    <= zero_dir ? STEP_W'(0) : sx_next;
            step_y    <= zero_dir ? STEP_W'(0) : sy_next;
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/unit_step_random_walk_core.sv =====
// Planar random walker: each accepted beat with tick high advances two 31-bit congruential
// generators, turns their states into a centered direction, scales it to unit length and adds
// it to saturating signed position accumulators; a beat with tick low is consumed with no result.
// A step runs through a squaring state, the bit-serial square root and the two restoring
// dividers that run side by side, then waits in the accumulate state until the output is
// free; a zero direction goes straight to accumulation. Up to two pending beats are
// buffered ahead of the arithmetic. Seed writes load the generators at once; the user must
// make them only while the block is idle, which the block itself does not enforce.
module unit_step_random_walk_core #(
  parameter int FRAC_BITS = 16,
  parameter int POS_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [usrw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [usrw_pkg::GEN_W-1:0]     cfg_data,
  usrw_tick_if.sink                      in_ch,
  usrw_result_if.source                  out_ch
);

  usrw_pkg::fifo_stat_t stat;
  usrw_pkg::dir_t       push_dir;
  usrw_pkg::dir_t       head;
  logic                 push;
  logic                 pop;

  usrw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .stat      (stat),
    .push      (push),
    .push_dir  (push_dir)
  );

  usrw_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_dir (push_dir),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  usrw_back #(
    .FRAC_BITS (FRAC_BITS),
    .POS_WIDTH (POS_WIDTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .stat   (stat),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && stat.full))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && stat.empty))
    else $error("pop from an empty queue");

  a_ready_tracks_queue: assert property (@(posedge clk) disable iff (rst)
      in_ch.ready == !stat.full)
    else $error("input ready disagrees with queue occupancy");

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [30:0] GEN_MASK = 31'h7FFF_FFFF;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          SETTLE_CYCLES = 120;

  typedef struct {
    logic signed [usrw_pkg::POS_OUT_W-1:0]  pos_x;
    logic signed [usrw_pkg::POS_OUT_W-1:0]  pos_y;
    logic signed [usrw_pkg::STEP_OUT_W-1:0] step_x;
    logic signed [usrw_pkg::STEP_OUT_W-1:0] step_y;
  } walk_pos_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [usrw_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [usrw_pkg::GEN_W-1:0]     cfg_data;

  usrw_tick_if   tick_ch ();
  usrw_result_if pos_ch ();

  unit_step_random_walk_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (tick_ch.sink),
    .out_ch    (pos_ch.source)
  );

  logic [30:0] walk_gen_x;
  logic [30:0] walk_gen_y;
  longint      walk_acc_x;
  longint      walk_acc_y;
  walk_pos_t   pending_pos[$];
  int          errors;
  int          burst_left;
  int          quiet_cycles;
  int          stall_mode;
  int          mode_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [30:0] lcg_advance(logic [30:0] s);
    logic [63:0] v;
    v = 64'(s) * 64'd214013 + 64'd2531011;
    return v[30:0];
  endfunction

  // Seed whose successor is the given state; the multiplier is odd, so its
  // inverse modulo a power of two follows from Newton iteration.
  function automatic logic [30:0] lcg_preimage(logic [30:0] target);
    logic [31:0] inv;
    logic [31:0] s;
    inv = 32'd214013;
    repeat (5) inv = inv * (32'd2 - 32'd214013 * inv);
    s = (32'(target) - 32'd2531011) * inv;
    return s[30:0];
  endfunction

  function automatic longint floor_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return longint'(root);
  endfunction

  function automatic longint unit_component(longint d, longint len);
    longint mag;
    longint q;
    mag = (d < 0) ? -d : d;
    q = ((mag << 16) + (len >> 1)) / len;
    return (d < 0) ? -q : q;
  endfunction

  function automatic longint sat_position(longint acc, longint stp);
    longint maxv;
    longint minv;
    maxv = 64'sh7FFF_FFFF;
    minv = -maxv - 1;
    if (stp > 0 && acc > maxv - stp) return maxv;
    if (stp < 0 && acc < minv - stp) return minv;
    return acc + stp;
  endfunction

  function automatic void predict_walk_step();
    longint    dx;
    longint    dy;
    longint    sx;
    longint    sy;
    longint    len;
    walk_pos_t p;
    walk_gen_x = lcg_advance(walk_gen_x);
    walk_gen_y = lcg_advance(walk_gen_y);
    dx = longint'(walk_gen_x) - 64'sh4000_0000;
    dy = longint'(walk_gen_y) - 64'sh4000_0000;
    sx = 0;
    sy = 0;
    if (dx != 0 || dy != 0) begin
      len = floor_sqrt(64'(dx * dx + dy * dy));
      sx = unit_component(dx, len);
      sy = unit_component(dy, len);
    end
    walk_acc_x = sat_position(walk_acc_x, sx);
    walk_acc_y = sat_position(walk_acc_y, sy);
    p.pos_x  = walk_acc_x[31:0];
    p.pos_y  = walk_acc_y[31:0];
    p.step_x = sx[17:0];
    p.step_y = sy[17:0];
    pending_pos.push_back(p);
  endfunction

  task automatic send_tick(input logic t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 70);
      if (gap > 0) begin
        tick_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    tick_ch.valid <= 1'b1;
    tick_ch.tick  <= t;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    burst_left--;
    if (t) predict_walk_step();
  endtask

  task automatic drain_walk();
    tick_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_pos.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [usrw_pkg::CFG_IDX_W-1:0] idx,
                            input logic [30:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == usrw_pkg::CFG_SEED_X) walk_gen_x = val;
    else walk_gen_y = val;
  endtask

  task automatic test_reset_seeds();
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    drain_walk();
  endtask

  task automatic test_seed_extremes();
    write_seed(usrw_pkg::CFG_SEED_X, 31'd0);
    write_seed(usrw_pkg::CFG_SEED_Y, GEN_MASK);
    repeat (3) send_tick(1'b1);
    drain_walk();
    write_seed(usrw_pkg::CFG_SEED_X, GEN_MASK);
    write_seed(usrw_pkg::CFG_SEED_Y, 31'd0);
    repeat (3) send_tick(1'b1);
    drain_walk();
  endtask

  task automatic test_zero_direction();
    write_seed(usrw_pkg::CFG_SEED_X, lcg_preimage(31'h4000_0000));
    write_seed(usrw_pkg::CFG_SEED_Y, lcg_preimage(31'h4000_0000));
    send_tick(1'b1);
    send_tick(1'b1);
    drain_walk();
    write_seed(usrw_pkg::CFG_SEED_X, lcg_preimage(31'h4000_0000));
    write_seed(usrw_pkg::CFG_SEED_Y, 31'd77);
    send_tick(1'b1);
    drain_walk();
    write_seed(usrw_pkg::CFG_SEED_X, 31'd5);
    write_seed(usrw_pkg::CFG_SEED_Y, lcg_preimage(31'h4000_0000));
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    drain_walk();
  endtask

  task automatic test_random_walk();
    for (int ph = 0; ph < 6; ph++) begin
      write_seed(usrw_pkg::CFG_SEED_X, 31'($urandom()) & GEN_MASK);
      write_seed(usrw_pkg::CFG_SEED_Y, 31'($urandom()) & GEN_MASK);
      repeat (105) send_tick($urandom_range(0, 7) != 0);
      drain_walk();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pos_ch.ready <= 1'b0;
      mode_left    <= 0;
    end else begin
      if (pos_ch.valid && pos_ch.ready) begin
        if (pending_pos.size() == 0) begin
          $error("unexpected beat: pos_x %0d pos_y %0d", pos_ch.pos_x, pos_ch.pos_y);
          errors++;
        end else begin
          walk_pos_t e;
          e = pending_pos.pop_front();
          if (pos_ch.pos_x !== e.pos_x) begin
            $error("pos_x expected %0d actual %0d", e.pos_x, pos_ch.pos_x);
            errors++;
          end
          if (pos_ch.pos_y !== e.pos_y) begin
            $error("pos_y expected %0d actual %0d", e.pos_y, pos_ch.pos_y);
            errors++;
          end
          if (pos_ch.step_x !== e.step_x) begin
            $error("step_x expected %0d actual %0d", e.step_x, pos_ch.step_x);
            errors++;
          end
          if (pos_ch.step_y !== e.step_y) begin
            $error("step_y expected %0d actual %0d", e.step_y, pos_ch.step_y);
            errors++;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: begin
          pos_ch.ready <= 1'b1;
        end
        1: begin
          pos_ch.ready <= $urandom_range(0, 3) != 0;
        end
        default: begin
          pos_ch.ready <= $urandom_range(0, 3) == 0;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (pos_ch.valid && pos_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    errors        = 0;
    burst_left    = 0;
    walk_gen_x    = usrw_pkg::SEED_X_RST;
    walk_gen_y    = usrw_pkg::SEED_Y_RST;
    walk_acc_x    = 0;
    walk_acc_y    = 0;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= usrw_pkg::CFG_SEED_X;
    cfg_data      <= '0;
    tick_ch.valid <= 1'b0;
    tick_ch.tick  <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_seeds();
    test_seed_extremes();
    test_zero_direction();
    test_random_walk();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/usrw_pkg.sv
rtl/usrw_if.sv
rtl/usrw_front.sv
rtl/usrw_fifo.sv
rtl/usrw_back.sv
rtl/unit_step_random_walk_core.sv
bench/tb.sv
